/* rtl/cb_prefix_bit_op_executor_macros.svh */
// Assertion macros shared by the checker of the CB-prefix bit-operation executor.
`ifndef CB_PREFIX_BIT_OP_EXECUTOR_MACROS_SVH
`define CB_PREFIX_BIT_OP_EXECUTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and idle during reset.
`define CBPX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock and idle during reset.
`define CBPX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cbpx_pkg.sv */
// Types and constants of the CB-prefix bit-operation executor.
package cbpx_pkg;

	// Register file geometry: B, C, D, E, H, L, A.
	localparam int NUM_REGS = 7;
	localparam int SLOT_W   = 3;

	localparam logic [SLOT_W-1:0] SLOT_H = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_L = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_A = 3'd6;

	// Operand and load selects.
	localparam logic [2:0] SEL_MEM        = 3'd6;
	localparam logic [2:0] SEL_A          = 3'd7;
	localparam logic [2:0] LOAD_IDX_FLAGS = 3'd6;

	// Modes.
	localparam logic MODE_EXEC = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	// Opcode groups in bits 7..6.
	localparam logic [1:0] GRP_SHIFT = 2'd0;
	localparam logic [1:0] GRP_BIT   = 2'd1;
	localparam logic [1:0] GRP_RES   = 2'd2;
	localparam logic [1:0] GRP_SET   = 2'd3;

	// Shift and rotate operations in bits 5..3.
	localparam logic [2:0] SH_RLC  = 3'd0;
	localparam logic [2:0] SH_RRC  = 3'd1;
	localparam logic [2:0] SH_RL   = 3'd2;
	localparam logic [2:0] SH_RR   = 3'd3;
	localparam logic [2:0] SH_SLA  = 3'd4;
	localparam logic [2:0] SH_SRA  = 3'd5;
	localparam logic [2:0] SH_SWAP = 3'd6;
	localparam logic [2:0] SH_SRL  = 3'd7;

	// Flag bit positions: Z, N, H, C.
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// Reported cycle counts.
	localparam logic [4:0] CYC_LOAD = 5'd0;
	localparam logic [4:0] CYC_REG  = 5'd8;
	localparam logic [4:0] CYC_MEM  = 5'd16;

	// One input beat.
	typedef struct packed {
		logic       mode;
		logic [7:0] opcode;
		logic [7:0] mem_read_data;
		logic [2:0] load_index;
		logic [7:0] load_value;
	} cbpx_item_t;

	// One result beat.
	typedef struct packed {
		logic [7:0]  result_value;
		logic [3:0]  flags_out;
		logic        mem_write;
		logic [15:0] mem_address;
		logic [7:0]  mem_write_data;
		logic [4:0]  cycles;
	} cbpx_result_t;

	// Write-back request from the execute logic to the register state.
	typedef struct packed {
		logic              reg_en;
		logic [SLOT_W-1:0] reg_slot;
		logic [7:0]        reg_data;
		logic              flag_en;
		logic [3:0]        flag_data;
	} cbpx_wr_t;

	// Map an operand or load select (never the memory code) to a register slot.
	function automatic logic [SLOT_W-1:0] to_slot(input logic [2:0] sel);
		logic [SLOT_W-1:0] slot;
		slot = (sel == SEL_A) ? SLOT_A : sel;
		return slot;
	endfunction

endpackage

/* rtl/cbpx_state.sv */
// Register file (B, C, D, E, H, L, A) and flag register with one write port.
module cbpx_state
	import cbpx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  cbpx_wr_t          wr,
	input  logic [2:0]        rd_sel,
	output logic [7:0]        rd_data,
	output logic [15:0]       hl,
	output logic [3:0]        flags
);

	logic [7:0] regs_q [NUM_REGS];
	logic [3:0] flags_q;

	// Registers and flags update, each under its own enable, when an item leaves the execute stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= 8'h00;
			end
			flags_q <= 4'h0;
		end else if (we) begin
			if (wr.reg_en) begin
				regs_q[wr.reg_slot] <= wr.reg_data;
			end
			if (wr.flag_en) begin
				flags_q <= wr.flag_data;
			end
		end
	end

	// Operand read; the memory code maps to A here and is ignored downstream.
	assign rd_data = regs_q[to_slot(rd_sel)];
	assign hl      = {regs_q[SLOT_H], regs_q[SLOT_L]};
	assign flags   = flags_q;

endmodule

/* rtl/cbpx_exec.sv */
// Combinational execute logic for CB-prefixed operations and register loads.
module cbpx_exec
	import cbpx_pkg::*;
(
	input  cbpx_item_t   item,
	input  logic [7:0]   operand,
	input  logic [15:0]  hl,
	input  logic [3:0]   flags,
	output cbpx_result_t result,
	output cbpx_wr_t     wr
);

	logic [2:0] sel;
	logic [2:0] sub;
	logic [1:0] grp;
	logic       is_mem;
	logic [7:0] v;
	logic [7:0] sh_res;
	logic       sh_c;
	logic [7:0] res;
	logic [3:0] new_flags;
	logic       writes;
	logic [7:0] bit_mask;

	assign sel      = item.opcode[2:0];
	assign sub      = item.opcode[5:3];
	assign grp      = item.opcode[7:6];
	assign is_mem   = (sel == SEL_MEM);
	assign v        = is_mem ? item.mem_read_data : operand;
	assign bit_mask = 8'h01 << sub;

	// Shift and rotate unit with the bit shifted out.
	always_comb begin
		case (sub)
			SH_RLC: begin
				sh_c   = v[7];
				sh_res = {v[6:0], v[7]};
			end
			SH_RRC: begin
				sh_c   = v[0];
				sh_res = {v[0], v[7:1]};
			end
			SH_RL: begin
				sh_c   = v[7];
				sh_res = {v[6:0], flags[FLAG_C]};
			end
			SH_RR: begin
				sh_c   = v[0];
				sh_res = {flags[FLAG_C], v[7:1]};
			end
			SH_SLA: begin
				sh_c   = v[7];
				sh_res = {v[6:0], 1'b0};
			end
			SH_SRA: begin
				sh_c   = v[0];
				sh_res = {v[7], v[7:1]};
			end
			SH_SWAP: begin
				sh_c   = 1'b0;
				sh_res = {v[3:0], v[7:4]};
			end
			default: begin
				sh_c   = v[0];
				sh_res = {1'b0, v[7:1]};
			end
		endcase
	end

	// Group decode: result byte, new flags and whether the operand is written.
	always_comb begin
		res       = v;
		new_flags = flags;
		writes    = 1'b1;
		case (grp)
			GRP_SHIFT: begin
				res                 = sh_res;
				new_flags           = 4'h0;
				new_flags[FLAG_Z]   = (sh_res == 8'h00);
				new_flags[FLAG_C]   = sh_c;
			end
			GRP_BIT: begin
				res               = v;
				writes            = 1'b0;
				new_flags[FLAG_Z] = ~v[sub];
				new_flags[FLAG_N] = 1'b0;
				new_flags[FLAG_H] = 1'b1;
			end
			GRP_RES: begin
				res = v & ~bit_mask;
			end
			default: begin
				res = v | bit_mask;
			end
		endcase
	end

	// Result beat and write-back request for both modes.
	always_comb begin
		result.mem_address = hl;
		wr.reg_slot        = to_slot(sel);
		wr.reg_data        = res;
		if (item.mode == MODE_LOAD) begin
			result.result_value   = item.load_value;
			result.mem_write      = 1'b0;
			result.mem_write_data = 8'h00;
			result.cycles         = CYC_LOAD;
			wr.reg_slot           = to_slot(item.load_index);
			wr.reg_data           = item.load_value;
			wr.flag_en            = (item.load_index == LOAD_IDX_FLAGS);
			wr.reg_en             = (item.load_index != LOAD_IDX_FLAGS);
			wr.flag_data          = item.load_value[7:4];
			result.flags_out      = wr.flag_en ? item.load_value[7:4] : flags;
		end else begin
			result.result_value   = res;
			result.mem_write      = writes && is_mem;
			result.mem_write_data = (writes && is_mem) ? res : 8'h00;
			result.cycles         = is_mem ? CYC_MEM : CYC_REG;
			wr.reg_en             = writes && !is_mem;
			wr.flag_en            = 1'b1;
			wr.flag_data          = new_flags;
			result.flags_out      = new_flags;
		end
	end

endmodule

/* rtl/cb_prefix_bit_op_executor.sv */
// Top level of the CB-prefix bit-operation executor.
//
// Input channel: item_valid, item_stall and the item struct (mode, opcode,
// mem_read_data, load_index, load_value). A beat moves when item_valid is
// high and item_stall is low at a rising edge of clk.
// Result channel: result_valid, result_stall and the result struct, with the
// same rule; exactly one result beat leaves for every input beat, in order.
// The input beat is registered in the input register, executed against the
// register file and flags once the result register can take it, and lands in
// the result register, from which it leaves while result_stall is low.
// One beat is taken every cycle while nothing stalls: the register file and
// flags are updated at the same edge that loads the result register, so the
// following beat sees them at once.
// While result_stall holds a full result register, the result holds steady
// and item_stall rises once the input register is also full.
// The asynchronous active-low reset empties both stages and clears all seven
// registers and the four flags to zero.
module cb_prefix_bit_op_executor
	import cbpx_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  cbpx_item_t   item,
	output logic         result_valid,
	input  logic         result_stall,
	output cbpx_result_t result
);

	logic         valid_s1;
	cbpx_item_t   item_s1;
	logic         valid_s2;
	cbpx_result_t result_s2;
	logic         s2_open;
	logic         fire;
	logic [7:0]   operand;
	logic [15:0]  hl;
	logic [3:0]   flags;
	cbpx_result_t exec_result;
	cbpx_wr_t     exec_wr;

	// Stage handshakes: the result register takes a beat when empty or draining.
	assign s2_open    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && s2_open;
	assign item_stall = valid_s1 && !s2_open;

	// Valid bits of the input and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (s2_open) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_s2 <= exec_result;
		end
	end

	cbpx_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (fire),
		.wr      (exec_wr),
		.rd_sel  (item_s1.opcode[2:0]),
		.rd_data (operand),
		.hl      (hl),
		.flags   (flags)
	);

	cbpx_exec u_exec (
		.item    (item_s1),
		.operand (operand),
		.hl      (hl),
		.flags   (flags),
		.result  (exec_result),
		.wr      (exec_wr)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

/* rtl/cbpx_checker.sv */
// Port-level checker for the CB-prefix bit-operation executor and its bind.
`include "cb_prefix_bit_op_executor_macros.svh"

module cbpx_checker
	import cbpx_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         result_valid,
	input logic         result_stall,
	input cbpx_result_t result
);

	// A stalled result beat stays offered and unchanged.
	`CBPX_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result beat changed")

	// A memory write only comes from the memory form of an operation.
	`CBPX_ASSERT_NOW(a_mem_write_cycles, result_valid && result.mem_write, result.cycles == CYC_MEM, "memory write without memory-form cycle count")

	// Write data is zero whenever no memory write is requested.
	`CBPX_ASSERT_NOW(a_write_data_zero, result_valid && !result.mem_write, result.mem_write_data == 8'h00, "write data set without memory write")

	// The cycles field only shows the load, register or memory-form value.
	`CBPX_ASSERT_NOW(a_cycle_codes, result_valid, result.cycles == CYC_LOAD || result.cycles == CYC_REG || result.cycles == CYC_MEM, "unexpected cycle count")

endmodule

bind cb_prefix_bit_op_executor cbpx_checker u_cbpx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

/* tb/sv/tb_cb_prefix_bit_op_executor.sv */
// Self-checking testbench for the CB-prefix bit-operation executor.
module tb_cb_prefix_bit_op_executor;
	import cbpx_pkg::*;

	// Operand and load selects that the package leaves unnamed.
	localparam logic [2:0] SEL_B = 3'd0;
	localparam logic [2:0] SEL_C = 3'd1;
	localparam logic [2:0] SEL_D = 3'd2;
	localparam logic [2:0] SEL_E = 3'd3;
	localparam logic [2:0] SEL_H = 3'd4;
	localparam logic [2:0] SEL_L = 3'd5;

	localparam int RANDOM_ITEMS = 850;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// Tracks the register file and flags, and holds the results still owed.
	class cb_result_board;
		logic [7:0]   regs [NUM_REGS];
		logic [3:0]   flags;
		cbpx_result_t pending_results [$];
		int           errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			flags  = '0;
			errors = 0;
		endfunction

		// Register file slot of a select that is not the memory code.
		function automatic logic [SLOT_W-1:0] reg_index(logic [2:0] sel);
			return (sel == SEL_A) ? SLOT_A : sel;
		endfunction

		// Execute one accepted beat against the tracked state and queue its result.
		function void take_item(cbpx_item_t it);
			cbpx_result_t r;
			logic [2:0]   sel;
			logic [2:0]   sub;
			logic [1:0]   grp;
			logic [7:0]   v;
			logic [7:0]   res;
			logic         cout;
			logic         writes;
			logic         is_mem;
			r = '0;
			r.mem_address = {regs[SLOT_H], regs[SLOT_L]};
			res = it.load_value;
			if (it.mode == MODE_LOAD) begin
				if (it.load_index == LOAD_IDX_FLAGS) begin
					flags = it.load_value[7:4];
				end else begin
					regs[reg_index(it.load_index)] = it.load_value;
				end
				r.cycles = CYC_LOAD;
			end else begin
				sel    = it.opcode[2:0];
				sub    = it.opcode[5:3];
				grp    = it.opcode[7:6];
				is_mem = (sel == SEL_MEM);
				v      = is_mem ? it.mem_read_data : regs[reg_index(sel)];
				res    = v;
				cout   = 1'b0;
				writes = 1'b1;
				case (grp)
					GRP_SHIFT: begin
						case (sub)
							SH_RLC: begin
								cout = v[7];
								res  = {v[6:0], v[7]};
							end
							SH_RRC: begin
								cout = v[0];
								res  = {v[0], v[7:1]};
							end
							SH_RL: begin
								cout = v[7];
								res  = {v[6:0], flags[FLAG_C]};
							end
							SH_RR: begin
								cout = v[0];
								res  = {flags[FLAG_C], v[7:1]};
							end
							SH_SLA: begin
								cout = v[7];
								res  = {v[6:0], 1'b0};
							end
							SH_SRA: begin
								cout = v[0];
								res  = {v[7], v[7:1]};
							end
							SH_SWAP: begin
								cout = 1'b0;
								res  = {v[3:0], v[7:4]};
							end
							default: begin
								cout = v[0];
								res  = {1'b0, v[7:1]};
							end
						endcase
						flags         = '0;
						flags[FLAG_Z] = (res == 8'h00);
						flags[FLAG_C] = cout;
					end
					GRP_BIT: begin
						writes        = 1'b0;
						flags[FLAG_Z] = ~v[sub];
						flags[FLAG_N] = 1'b0;
						flags[FLAG_H] = 1'b1;
					end
					GRP_RES: begin
						res[sub] = 1'b0;
					end
					default: begin
						res[sub] = 1'b1;
					end
				endcase
				if (writes) begin
					if (is_mem) begin
						r.mem_write      = 1'b1;
						r.mem_write_data = res;
					end else begin
						regs[reg_index(sel)] = res;
					end
				end
				r.cycles = is_mem ? CYC_MEM : CYC_REG;
			end
			r.result_value = res;
			r.flags_out    = flags;
			pending_results.push_back(r);
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
					$time, field, want, got);
				errors++;
			end
		endfunction

		// Match one result beat against the oldest owed result.
		function void check_result(cbpx_result_t got);
			cbpx_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual 0x%0h",
					$time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				compare("result_value", 16'(want.result_value), 16'(got.result_value));
				compare("flags_out", 16'(want.flags_out), 16'(got.flags_out));
				compare("mem_write", 16'(want.mem_write), 16'(got.mem_write));
				compare("mem_address", want.mem_address, got.mem_address);
				compare("mem_write_data", 16'(want.mem_write_data),
					16'(got.mem_write_data));
				compare("cycles", 16'(want.cycles), 16'(got.cycles));
			end
		endfunction
	endclass

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         item_valid   = 1'b0;
	logic         item_stall;
	cbpx_item_t   item_beat    = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	cbpx_result_t result_beat;

	cb_result_board board;
	bit             idle_on   = 1'b1;
	int unsigned    cycle_cnt = 0;

	cb_prefix_bit_op_executor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_beat)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Check every result beat that the sink accepts.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			board.check_result(result_beat);
		end
	end

	// Result sink: stall a random number of cycles, then take one beat.
	initial begin : result_sink
		int hold;
		forever begin
			hold = idle_on ? $urandom_range(0, 3) : 0;
			@(negedge clk);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(arst_n && result_valid));
		end
	end

	// Present one input beat after a random gap and hold it until it is taken.
	task automatic send_beat(cbpx_item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_beat  <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		board.take_item(it);
	endtask

	// Load mode beat; the opcode and memory byte carry noise.
	task automatic send_load(logic [2:0] idx, logic [7:0] value);
		cbpx_item_t it;
		it.mode          = MODE_LOAD;
		it.opcode        = 8'($urandom_range(0, 255));
		it.mem_read_data = 8'($urandom_range(0, 255));
		it.load_index    = idx;
		it.load_value    = value;
		send_beat(it);
	endtask

	// Execute mode beat; the load fields carry noise.
	task automatic send_exec(logic [1:0] grp, logic [2:0] sub, logic [2:0] sel,
		logic [7:0] mem_byte);
		cbpx_item_t it;
		it.mode          = MODE_EXEC;
		it.opcode        = {grp, sub, sel};
		it.mem_read_data = mem_byte;
		it.load_index    = 3'($urandom_range(0, 7));
		it.load_value    = 8'($urandom_range(0, 255));
		send_beat(it);
	endtask

	initial begin : stimulus
		cbpx_item_t it;
		board = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: seed every register, mostly with extremes, and flags with junk low bits.
		send_load(SEL_B, 8'h00);
		send_load(SEL_C, 8'hFF);
		send_load(SEL_D, 8'h80);
		send_load(SEL_E, 8'h01);
		send_load(SEL_H, 8'hC0);
		send_load(SEL_L, 8'h3A);
		send_load(SEL_A, 8'h7F);
		send_load(LOAD_IDX_FLAGS, 8'hFF);
		// Rotates through carry with carry set, then every other shift.
		send_exec(GRP_SHIFT, SH_RL, SEL_D, 8'h00);
		send_exec(GRP_SHIFT, SH_RR, SEL_E, 8'h00);
		send_exec(GRP_SHIFT, SH_RLC, SEL_B, 8'h00);
		send_exec(GRP_SHIFT, SH_RRC, SEL_C, 8'h00);
		send_exec(GRP_SHIFT, SH_SLA, SEL_MEM, 8'h80);
		send_exec(GRP_SHIFT, SH_SRA, SEL_A, 8'h00);
		send_exec(GRP_SHIFT, SH_SWAP, SEL_MEM, 8'hF0);
		send_exec(GRP_SHIFT, SH_SRL, SEL_C, 8'hFF);
		// Bit test on memory writes nothing back.
		send_exec(GRP_BIT, 3'd7, SEL_MEM, 8'h00);
		send_exec(GRP_BIT, 3'd0, SEL_A, 8'hFF);
		send_exec(GRP_RES, 3'd7, SEL_MEM, 8'hFF);
		send_exec(GRP_SET, 3'd0, SEL_MEM, 8'h00);
		send_exec(GRP_RES, 3'd3, SEL_H, 8'h00);
		send_exec(GRP_SET, 3'd7, SEL_L, 8'h00);
		send_load(LOAD_IDX_FLAGS, 8'h0F);
		send_exec(GRP_SHIFT, SH_SWAP, SEL_B, 8'h00);
		send_exec(GRP_BIT, 3'd4, SEL_C, 8'h00);

		// Random: mostly opcodes, with loads sprinkled in; idling switches per phase.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				idle_on = ($urandom_range(0, 3) != 0);
			end
			it.mode          = ($urandom_range(0, 4) == 0) ? MODE_LOAD : MODE_EXEC;
			it.opcode        = 8'($urandom_range(0, 255));
			it.mem_read_data = 8'($urandom_range(0, 255));
			it.load_index    = 3'($urandom_range(0, 7));
			it.load_value    = 8'($urandom_range(0, 255));
			send_beat(it);
		end
		idle_on = 1'b1;
		@(negedge clk);
		item_valid <= 1'b0;

		// Drain the results still owed, then watch for strays.
		while (board.pending_results.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/cbpx_pkg.sv
rtl/cbpx_state.sv
rtl/cbpx_exec.sv
rtl/cb_prefix_bit_op_executor.sv
rtl/cbpx_checker.sv
tb/sv/tb_cb_prefix_bit_op_executor.sv
